[sv/trial_division_prime_counter_assert.svh]
// assertion macros shared by the prime counter modules
// no dependencies; expects aclk and aresetn in the including module
`ifndef TRIAL_DIVISION_PRIME_COUNTER_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_COUNTER_ASSERT_SVH
`ifndef SYNTH
`define TDPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define TDPC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TDPC_ASSERT_IMP(label, ante, cons, msg)
`define TDPC_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

[sv/tdpc_pkg.sv]
// widths, constants and controller/datapath handshake types for the prime counter
// no dependencies
package tdpc_pkg;

    localparam int VALUE_BITS    = 16;
    localparam int COUNT_BITS    = 16;
    localparam int RADIX_STEPS   = 4;
    localparam int DIV_CYCLES    = (VALUE_BITS + RADIX_STEPS - 1) / RADIX_STEPS;
    localparam int SHIFT_W       = DIV_CYCLES * RADIX_STEPS;
    localparam int STEP_W        = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int DIV_W         = VALUE_BITS / 2 + 1;
    localparam int SQ_W          = VALUE_BITS + 1;
    localparam int S_TDATA_W     = ((VALUE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W     = ((1 + COUNT_BITS + 7) / 8) * 8;
    localparam int FIRST_DIVISOR = 2;

    typedef struct packed {
        logic load;
        logic start_div;
        logic div_step;
        logic advance;
        logic set_prime;
        logic clr_prime;
        logic retire;
    } cmd_t;

    typedef struct packed {
        logic below_two;
        logic sq_gt;
        logic last_step;
        logic rem_zero;
        logic out_busy;
    } status_t;

endpackage

[sv/tdpc_ctrl.sv]
// controller state machine: sequences trial divisors and the result handoff
// depends on tdpc_pkg and trial_division_prime_counter_assert.svh
`include "trial_division_prime_counter_assert.svh"

module tdpc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  tdpc_pkg::status_t st,
    output tdpc_pkg::cmd_t    cmd
);
    import tdpc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_TRIAL  = 4'b0010,
        S_DIV    = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_TRIAL;
                end
            end
            S_TRIAL: begin
                if (st.below_two) begin
                    cmd.clr_prime = 1'b1;
                    state_next    = S_FINISH;
                end else if (st.sq_gt) begin
                    // every divisor up to the square root tried
                    cmd.set_prime = 1'b1;
                    state_next    = S_FINISH;
                end else begin
                    cmd.start_div = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (st.last_step) begin
                    if (st.rem_zero) begin
                        cmd.clr_prime = 1'b1;
                        state_next    = S_FINISH;
                    end else begin
                        cmd.advance = 1'b1;
                        state_next  = S_TRIAL;
                    end
                end
            end
            S_FINISH: begin
                if (!st.out_busy) begin
                    cmd.retire = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `TDPC_ASSERT_IMP(a_prime_needs_bound, cmd.set_prime, st.sq_gt && !st.below_two,
        "prime declared before divisor bound reached")
    `TDPC_ASSERT_NXT(a_advance_to_trial, cmd.advance, state_reg == S_TRIAL,
        "next divisor not followed by a bound check")

endmodule

[sv/tdpc_datapath.sv]
// datapath: divisor and square tracking, 4-bit-per-cycle remainder unit,
// running count and output register; depends on tdpc_pkg and the assert header
`include "trial_division_prime_counter_assert.svh"

module tdpc_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tdpc_pkg::cmd_t                  cmd,
    output tdpc_pkg::status_t               st,
    input  logic [tdpc_pkg::VALUE_BITS-1:0] in_value,
    input  logic                            in_clear,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [tdpc_pkg::M_TDATA_W-1:0]  m_tdata
);
    import tdpc_pkg::*;

    logic [VALUE_BITS-1:0] value_reg;
    logic                  clear_reg;
    logic [DIV_W-1:0]      div_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [SHIFT_W-1:0]    shift_reg, shift_next;
    logic [STEP_W-1:0]     step_reg;
    logic                  prime_reg;
    logic [COUNT_BITS-1:0] count_reg, count_next, count_base;
    logic                  out_valid_reg;
    logic                  out_prime_reg;
    logic [COUNT_BITS-1:0] out_count_reg;

    // restoring remainder, one bit of the value per inner step
    always_comb begin : rem_unit
        logic [DIV_W:0] trial;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        trial      = '0;
        for (int i = 0; i < RADIX_STEPS; i++) begin
            trial      = {rem_next, shift_next[SHIFT_W-1]};
            shift_next = {shift_next[SHIFT_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                trial = trial - {1'b0, div_reg};
            end
            rem_next = trial[DIV_W-1:0];
        end
    end

    always_comb begin
        count_base = clear_reg ? '0 : count_reg;
        count_next = count_base;
        if (prime_reg && (count_base != {COUNT_BITS{1'b1}})) begin
            count_next = count_base + COUNT_BITS'(1);
        end
    end

    assign st.below_two = (value_reg < VALUE_BITS'(FIRST_DIVISOR));
    assign st.sq_gt     = (sq_reg > {1'b0, value_reg});
    assign st.last_step = (step_reg == STEP_W'(DIV_CYCLES - 1));
    assign st.rem_zero  = (rem_next == '0);
    assign st.out_busy  = out_valid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            value_reg <= in_value;
            clear_reg <= in_clear;
            div_reg   <= DIV_W'(FIRST_DIVISOR);
            sq_reg    <= SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR);
        end
        if (cmd.start_div) begin
            rem_reg   <= '0;
            shift_reg <= SHIFT_W'(value_reg);
            step_reg  <= '0;
        end
        if (cmd.div_step) begin
            rem_reg   <= rem_next;
            shift_reg <= shift_next;
            step_reg  <= step_reg + STEP_W'(1);
        end
        if (cmd.advance) begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_reg  <= sq_reg + SQ_W'({div_reg, 1'b1});
            div_reg <= div_reg + DIV_W'(1);
        end
        if (cmd.set_prime) begin
            prime_reg <= 1'b1;
        end else if (cmd.clr_prime) begin
            prime_reg <= 1'b0;
        end
        if (cmd.retire) begin
            out_prime_reg <= prime_reg;
            out_count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.retire) begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_count_reg, out_prime_reg});

    `TDPC_ASSERT_IMP(a_rem_below_div, cmd.div_step, rem_reg < div_reg,
        "partial remainder not below divisor")
    `TDPC_ASSERT_NXT(a_count_nonzero, cmd.retire && prime_reg, count_reg != '0,
        "prime retired but count is zero")

endmodule

[sv/trial_division_prime_counter.sv]
// top level of the trial-division prime counter
// depends on tdpc_pkg, tdpc_ctrl and tdpc_datapath
//
//   port group  dir  tdata                               tuser
//   s_          in   [15:0] value                        [0] clear_count
//   m_          out  [0] is_prime, [16:1] prime_count    -
//
// one word at a time; each divisor tried takes a bound check and then a division
// in the shared remainder unit, which retires 4 value bits per cycle. a prime is
// declared once the divisor's square exceeds the value, a composite as soon as a
// remainder is zero, and a value below two with no division. a finished word
// waits in the output register while the next word is accepted and tested. reset
// is synchronous and clears the running count and the output valid.

module trial_division_prime_counter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tdpc_pkg::S_TDATA_W-1:0] s_tdata,  // value
    input  logic [0:0]                     s_tuser,  // clear_count
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tdpc_pkg::M_TDATA_W-1:0] m_tdata   // is_prime, prime_count
);
    import tdpc_pkg::*;

    cmd_t    cmd;
    status_t st;

    tdpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    tdpc_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .st       (st),
        .in_value (s_tdata[VALUE_BITS-1:0]),
        .in_clear (s_tuser[0]),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule
